@@ src/ise_pkg.sv @@
// Shared types, constants and operand helpers for the instruction sequence enumerator.
// Used by ise_cell and instruction_sequence_enumerator; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

	localparam int MAX_SLOTS_DEF = 8;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 1'b1;

	localparam logic [4:0] NIN_MAX = 5'd26;

	// Operand kinds
	localparam logic [1:0] KIND_INPUT  = 2'd0;
	localparam logic [1:0] KIND_RESULT = 2'd1;
	localparam logic [1:0] KIND_CONST  = 2'd2;

	// Constants are held as value plus two
	localparam logic [4:0] CONST_LOW_MIN = 5'd0;
	localparam logic [4:0] CONST_LOW_MAX = 5'd4;

	// Stored opcodes and their reported numbers
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [3:0] OPC_ADD = 4'd8;
	localparam logic [3:0] OPC_SUB = 4'd10;
	localparam logic [3:0] OPC_MUL = 4'd12;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] low;
	} opnd_t;

	typedef struct packed {
		logic [1:0] op;
		opnd_t      a;
		opnd_t      b;
	} slot_t;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic load_first;
		logic commit;
		logic clear_pend;
		logic snap;
		logic shift;
	} cell_ctl_t;

	localparam opnd_t OPND_FIRST = '{kind: KIND_INPUT, low: 5'd0};

	function automatic logic [3:0] op_code(input logic [1:0] op);
		logic [3:0] r;
		begin
			case (op)
				OP_SUB:  r = OPC_SUB;
				OP_MUL:  r = OPC_MUL;
				default: r = OPC_ADD;
			endcase
			return r;
		end
	endfunction

	function automatic logic [4:0] opnd_index(input opnd_t o);
		return (o.kind == KIND_CONST) ? 5'd0 : o.low;
	endfunction

	// Constant value in three-bit two's complement
	function automatic logic [2:0] opnd_const(input opnd_t o);
		return (o.kind == KIND_CONST) ? (o.low[2:0] + 3'd6) : 3'd0;
	endfunction

endpackage

`default_nettype wire

@@ src/ise_cell.sv @@
// One instruction slot of the enumerator chain: slot state, carry token and output shift stage.
// Depends on ise_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ise_cell #(
	parameter int MAX_SLOTS = ise_pkg::MAX_SLOTS_DEF,
	parameter int POS = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ise_pkg::cell_ctl_t ctl,
	input  logic [4:0]        nin,
	input  logic              tok_in,
	input  ise_pkg::slot_t    sh_in,
	output ise_pkg::slot_t    sh_out,
	output logic              tok,
	output logic              hit,
	output logic              carry
);
	import ise_pkg::*;

	localparam int PW = $clog2(MAX_SLOTS + 1);
	localparam int CW = (PW > 6) ? PW : 6;
	localparam logic [CW-1:0] POS_W = CW'(POS);
	localparam logic IS_FIRST = (POS == 0);

	logic [1:0] op_q;
	opnd_t      a_q;
	opnd_t      b_q;
	logic       pend_q;
	logic       tok_q;
	slot_t      sh_q;

	logic       a_max;
	logic       b_max;
	logic       op_max;
	logic       can_adv;
	logic [1:0] op_n;
	opnd_t      a_n;
	opnd_t      b_n;

	// Step one operand to its successor in input, result, constant order
	function automatic opnd_t opnd_next(input opnd_t o, input logic [4:0] n);
		opnd_t r;
		logic [5:0] inc;
		logic [CW-1:0] inc_w;
		begin
			inc = {1'b0, o.low} + 6'd1;
			inc_w = CW'(inc);
			case (o.kind)
				KIND_INPUT: begin
					if (inc >= {1'b0, n}) begin
						r.kind = IS_FIRST ? KIND_CONST : KIND_RESULT;
						r.low = 5'd0;
					end else begin
						r.kind = KIND_INPUT;
						r.low = inc[4:0];
					end
				end
				KIND_RESULT: begin
					if (inc_w >= POS_W) begin
						r.kind = KIND_CONST;
						r.low = CONST_LOW_MIN;
					end else begin
						r.kind = KIND_RESULT;
						r.low = inc[4:0];
					end
				end
				default: begin
					r.kind = KIND_CONST;
					r.low = (o.low >= CONST_LOW_MAX) ? CONST_LOW_MAX : inc[4:0];
				end
			endcase
			return r;
		end
	endfunction

	// Decide whether this slot can absorb the carry
	assign b_max   = (b_q.kind == KIND_CONST) && (b_q.low == CONST_LOW_MAX);
	assign a_max   = (a_q.kind == KIND_CONST) && (a_q.low == CONST_LOW_MAX);
	assign op_max  = (op_q >= OP_MUL);
	assign can_adv = !(b_max && a_max && op_max);
	assign hit     = tok_q && can_adv;
	assign carry   = tok_q && !can_adv;
	assign tok     = tok_q;
	assign sh_out  = sh_q;

	// Next combination of this slot alone
	always_comb begin
		op_n = op_q;
		a_n = a_q;
		b_n = b_q;
		if (!b_max) begin
			b_n = opnd_next(b_q, nin);
		end else if (!a_max) begin
			a_n = opnd_next(a_q, nin);
			b_n = OPND_FIRST;
		end else begin
			op_n = op_q + 2'd1;
			a_n = OPND_FIRST;
			b_n = OPND_FIRST;
		end
	end

	// Slot state, pending reset flag and carry token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
			a_q <= OPND_FIRST;
			b_q <= OPND_FIRST;
			pend_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (ctl.load_first) begin
				op_q <= OP_ADD;
				a_q <= OPND_FIRST;
				b_q <= OPND_FIRST;
				pend_q <= 1'b0;
			end else if (hit) begin
				op_q <= op_n;
				a_q <= a_n;
				b_q <= b_n;
			end else if (ctl.clear_pend) begin
				pend_q <= 1'b0;
			end else if (carry) begin
				pend_q <= 1'b1;
			end else if (ctl.commit && pend_q) begin
				op_q <= OP_ADD;
				a_q <= OPND_FIRST;
				b_q <= OPND_FIRST;
				pend_q <= 1'b0;
			end
		end
	end

	// Output shift stage: capture the slot, then hand toward slot zero per beat
	always_ff @(posedge clk) begin
		if (ctl.snap) begin
			sh_q <= '{op: op_q, a: a_q, b: b_q};
		end else if (ctl.shift) begin
			sh_q <= sh_in;
		end
	end

endmodule

`default_nettype wire

@@ src/instruction_sequence_enumerator.sv @@
// Top level of the instruction sequence enumerator: config registers, sequencer, cell chain.
// Depends on ise_pkg and ise_cell.
//
// Usage: each input beat (restart) either reloads the first combination (restart = 1)
// or steps the odometer to the next combination (restart = 0). The block then sends
// one output beat per slot, slot 0 first, with last set on slot seq_length-1. Once
// every combination has been visited, an advance gives one beat with exhausted set
// and all other fields zero; further advances repeat it until a restart.
// Sequence: a restart reloads and captures the first combination, then sends
// seq_length beats. An advance first walks the carry token through k cells
// (1..seq_length), one cell per cycle from the last slot toward slot 0, until a
// cell takes it; the slots are then captured and seq_length beats follow. An
// advance that runs out of combinations sends its exhausted beat once the carry
// leaves slot 0, and a repeated one goes straight to sending.
// A new input beat is taken only after the last output beat of the previous one.
// Stalls: output beats come from a shift chain that only moves when out_ready is
// high; a stalled beat holds. Reset: num_inputs = 1, seq_length = 1, all slots hold
// add with input A as both operands, and the block is idle. Configuration may be
// written only while idle.
`timescale 1ns / 1ps
`default_nettype none

module instruction_sequence_enumerator #(
	parameter int MAX_SLOTS = ise_pkg::MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ise_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [4:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    slot,
	output logic [3:0]                    opcode,
	output logic [1:0]                    a_kind,
	output logic [4:0]                    a_index,
	output logic signed [2:0]             a_const,
	output logic [1:0]                    b_kind,
	output logic [4:0]                    b_index,
	output logic signed [2:0]             b_const,
	output logic                          last,
	output logic                          exhausted
);
	import ise_pkg::*;

	localparam int LW = $clog2(MAX_SLOTS + 1);
	localparam int LCW = (LW > 4) ? LW : 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_SNAP = 2'd2;
	localparam logic [1:0] ST_SEND = 2'd3;

	logic [4:0]    nin_q;
	logic [3:0]    len_q;
	logic [4:0]    nin_eff;
	logic [LW-1:0] len_eff;

	logic [1:0]    state_q;
	logic          done_q;
	logic          exh_q;
	logic [LW-1:0] rem_q;
	logic [2:0]    idx_q;

	logic          in_fire;
	logic          out_fire;
	logic          inject;
	logic          any_hit;
	cell_ctl_t     ctl;

	logic [MAX_SLOTS:0]   carry_w;
	logic [MAX_SLOTS-1:0] hit_w;
	logic [MAX_SLOTS-1:0] tok_w;
	slot_t                sh_w [0:MAX_SLOTS];
	slot_t                head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nin_q <= 5'd1;
			len_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NUM_INPUTS: nin_q <= cfg_data;
				REG_SEQ_LENGTH: len_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers to their usable ranges
	always_comb begin
		if (nin_q == 5'd0) begin
			nin_eff = 5'd1;
		end else if (nin_q > NIN_MAX) begin
			nin_eff = NIN_MAX;
		end else begin
			nin_eff = nin_q;
		end
		if (len_q == 4'd0) begin
			len_eff = LW'(1);
		end else if (LCW'(len_q) > LCW'(MAX_SLOTS)) begin
			len_eff = LW'(MAX_SLOTS);
		end else begin
			len_eff = LW'(len_q);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SEND);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign inject    = in_fire && !restart && !done_q;
	assign any_hit   = |hit_w;

	// Broadcast controls
	always_comb begin
		ctl.load_first = in_fire && restart;
		ctl.commit     = any_hit;
		ctl.clear_pend = carry_w[0];
		ctl.snap       = (state_q == ST_SNAP);
		ctl.shift      = out_fire;
	end

	// Chain of slot cells; the carry token walks from the last used slot toward slot 0
	assign carry_w[MAX_SLOTS] = 1'b0;
	assign sh_w[MAX_SLOTS] = '0;

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		logic tok_in;
		assign tok_in = (inject && (LW'(i + 1) == len_eff)) || carry_w[i + 1];

		ise_cell #(
			.MAX_SLOTS(MAX_SLOTS),
			.POS(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.nin(nin_eff),
			.tok_in(tok_in),
			.sh_in(sh_w[i + 1]),
			.sh_out(sh_w[i]),
			.tok(tok_w[i]),
			.hit(hit_w[i]),
			.carry(carry_w[i])
		);
	end

	// Sequencer: accept, walk the carry, capture, send beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			exh_q <= 1'b0;
			rem_q <= '0;
			idx_q <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (restart) begin
							done_q <= 1'b0;
							state_q <= ST_SNAP;
						end else if (done_q) begin
							exh_q <= 1'b1;
							state_q <= ST_SEND;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (any_hit) begin
						state_q <= ST_SNAP;
					end else if (carry_w[0]) begin
						done_q <= 1'b1;
						exh_q <= 1'b1;
						state_q <= ST_SEND;
					end
				end
				ST_SNAP: begin
					rem_q <= len_eff;
					idx_q <= 3'd0;
					exh_q <= 1'b0;
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_fire) begin
						if (exh_q || (rem_q == LW'(1))) begin
							state_q <= ST_IDLE;
						end else begin
							rem_q <= rem_q - LW'(1);
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Drive the beat from the head of the shift chain
	assign head      = sh_w[0];
	assign exhausted = exh_q;
	assign slot      = exh_q ? 3'd0 : idx_q;
	assign opcode    = exh_q ? 4'd0 : op_code(head.op);
	assign a_kind    = exh_q ? 2'd0 : head.a.kind;
	assign a_index   = exh_q ? 5'd0 : opnd_index(head.a);
	assign a_const   = exh_q ? 3'sd0 : signed'(opnd_const(head.a));
	assign b_kind    = exh_q ? 2'd0 : head.b.kind;
	assign b_index   = exh_q ? 5'd0 : opnd_index(head.b);
	assign b_const   = exh_q ? 3'sd0 : signed'(opnd_const(head.b));
	assign last      = !exh_q && (rem_q == LW'(1));

	// Exactly one token is in flight while scanning
	a_scan_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> $onehot(tok_w))
		else $error("carry token lost or duplicated during scan");

	// At most one cell takes the carry
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_w))
		else $error("more than one cell advanced");

	// A taken carry leads to the capture cycle
	a_hit_snap: assert property (@(posedge clk) disable iff (!arst_n)
		any_hit |=> (state_q == ST_SNAP))
		else $error("advance not followed by capture");

	// The exhausted beat is only sent once the space is used up
	a_exh_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SEND) && exh_q) |-> done_q)
		else $error("exhausted beat without done flag");

	// The final beat returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && (last || exhausted)) |=> (state_q == ST_IDLE))
		else $error("block not idle after final beat");

endmodule

`default_nettype wire
